// File: design/musical_key_detector_core_defines.svh
// ----------------------------------------------------------------------------
// Musical key detector assertion macros
// Property templates for the checks inside the detector controller.
// ----------------------------------------------------------------------------
`ifndef MUSICAL_KEY_DETECTOR_CORE_DEFINES_SVH
`define MUSICAL_KEY_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MKD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("key detector check failed");

// Next-cycle implication, disabled during reset.
`define MKD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("key detector check failed");

`endif

// File: design/mkd_pkg.sv
// ----------------------------------------------------------------------------
// Musical key detector package
// Opcodes, constants, profile ROM and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mkd_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam int unsigned NBINS       = 12;
  localparam int unsigned NKEYS       = 24;
  localparam logic [15:0] FREQ_MIN_Q4 = 16'd800;
  localparam logic [15:0] FREQ_MAX_Q4 = 16'd32000;
  localparam logic [16:0] POS_OFFSET  = 17'd2976;
  localparam logic [16:0] POS_SPAN    = 17'd3072;
  localparam logic [15:0] VOTING_RST  = 16'd1000;

  // Key profiles in Q8, major and minor.
  function automatic logic [10:0] prof_val(input logic minor, input logic [3:0] idx);
    logic [10:0] v;
    v = 11'd0;
    if (!minor) begin
      case (idx)
        4'd0:    v = 11'd1626;
        4'd1:    v = 11'd571;
        4'd2:    v = 11'd891;
        4'd3:    v = 11'd596;
        4'd4:    v = 11'd1121;
        4'd5:    v = 11'd1047;
        4'd6:    v = 11'd645;
        4'd7:    v = 11'd1329;
        4'd8:    v = 11'd612;
        4'd9:    v = 11'd937;
        4'd10:   v = 11'd586;
        4'd11:   v = 11'd737;
        default: v = 11'd0;
      endcase
    end else begin
      case (idx)
        4'd0:    v = 11'd1620;
        4'd1:    v = 11'd686;
        4'd2:    v = 11'd901;
        4'd3:    v = 11'd1377;
        4'd4:    v = 11'd666;
        4'd5:    v = 11'd904;
        4'd6:    v = 11'd650;
        4'd7:    v = 11'd1216;
        4'd8:    v = 11'd1019;
        4'd9:    v = 11'd689;
        4'd10:   v = 11'd855;
        4'd11:   v = 11'd812;
        default: v = 11'd0;
      endcase
    end
    return v;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic log_init;
    logic log_step;
    logic pos1;
    logic pos2;
    logic pos3;
    logic rd_lo;
    logic wr_lo;
    logic rd_hi;
    logic wr_hi;
    logic mac_start;
    logic div_init;
    logic div_step;
    logic key_upd;
    logic clr_init;
    logic clr_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic sample_ok;
    logic log_last;
    logic mac_done;
    logic div_last;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/mkd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mkd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/mkd_datapath.sv
// ----------------------------------------------------------------------------
// Musical key detector datapath
// Log2 pitch mapping, histogram update, profile scoring, divider and voting.
// ----------------------------------------------------------------------------
`default_nettype none

module mkd_datapath
  import mkd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic [47:0] in_data,
  input  wire logic [1:0]  in_op,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic      [31:0] out_data,
  output logic             ram_we,
  output logic      [3:0]  ram_waddr,
  output logic      [31:0] ram_wdata,
  output logic      [3:0]  ram_raddr,
  input  wire logic [31:0] ram_rdata
);

  // Request fields.
  op_t         op_r;
  logic [15:0] freq_r;
  logic [8:0]  wgt_r;
  logic [15:0] dt_r;
  logic [15:0] voting;

  // Pitch mapping.
  logic [3:0]  e_comb;
  logic [3:0]  e_r;
  logic [15:0] m_r;
  logic [15:0] frac_r;
  logic [4:0]  cnt;
  logic [31:0] sq;
  logic [16:0] sq15;
  logic [15:0] x_r;
  logic [11:0] p_r;
  logic [16:0] y;
  logic [5:0]  q3;
  logic [16:0] p0;
  logic [8:0]  wclip;
  logic [17:0] wprod;
  logic [8:0]  part_r;
  logic [8:0]  rest_r;
  logic [3:0]  lo_r;
  logic [3:0]  hi_r;
  logic [32:0] sum_lo;
  logic [32:0] sum_hi;

  // Scoring pipeline.
  logic        iss_act;
  logic [4:0]  iss_k;
  logic [3:0]  iss_i;
  logic        s1_v;
  logic [4:0]  s1_k;
  logic [3:0]  s1_i;
  logic [3:0]  rot;
  logic [3:0]  pidx;
  logic        s2_v;
  logic        s2_last;
  logic [4:0]  s2_k;
  logic [42:0] p2;
  logic [47:0] acc;
  logic        s3_v;
  logic [4:0]  s3_k;
  logic [47:0] fin_r;
  logic [52:0] total;
  logic [47:0] best;
  logic [4:0]  best_k;

  // Divider.
  logic [52:0] rem;
  logic [53:0] rem2;
  logic [16:0] quo;

  // Voting state.
  logic [3:0]  cand_root;
  logic        cand_minor;
  logic [16:0] cand_conf;
  logic [3:0]  conf_root;
  logic        conf_minor;
  logic [16:0] conf_level;
  logic [31:0] hold_ms;
  logic [3:0]  new_root;
  logic        new_minor;
  logic [16:0] new_conf;
  logic [32:0] hold_sum;
  logic [31:0] hold_new;

  // Top set bit of the frequency.
  always_comb begin
    e_comb = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (freq_r[b]) begin
        e_comb = 4'(b);
      end
    end
  end

  assign wclip = (wgt_r > 9'd256) ? 9'd256 : wgt_r;
  assign sq    = 32'(m_r) * 32'(m_r);
  assign sq15  = sq[31:15];

  // Position reduction modulo the pitch-class span.
  assign y  = 17'(x_r) + POS_OFFSET;
  assign q3 = 6'((14'(y[16:10]) * 14'd171) >> 9);
  assign p0 = y - 17'(q3) * POS_SPAN;

  assign wprod  = 18'(wclip) * 18'(9'd256 - 9'(p_r[7:0])) + 18'd128;
  assign sum_lo = 33'(ram_rdata) + 33'(part_r);
  assign sum_hi = 33'(ram_rdata) + 33'(rest_r);

  // Profile index for the key in the first scoring stage.
  assign rot  = (s1_k >= 5'd12) ? 4'(s1_k - 5'd12) : 4'(s1_k);
  assign pidx = (s1_i >= rot) ? (s1_i - rot) : (s1_i + 4'd12 - rot);

  assign rem2 = {rem, 1'b0};

  // Best key and its confidence.
  assign new_root  = (best_k >= 5'd12) ? 4'(best_k - 5'd12) : 4'(best_k);
  assign new_minor = (best_k >= 5'd12);
  assign new_conf  = (total == 53'd0) ? 17'd0 : quo;
  assign hold_sum  = 33'(hold_ms) + 33'(dt_r);
  assign hold_new  = hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];

  // Histogram memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_r;
    ram_wdata = 32'd0;
    ram_raddr = iss_i;
    if (cmd.rd_lo) begin
      ram_raddr = lo_r;
    end
    if (cmd.rd_hi) begin
      ram_raddr = hi_r;
    end
    if (cmd.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = lo_r;
      ram_wdata = sum_lo[32] ? 32'hFFFF_FFFF : sum_lo[31:0];
    end
    if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hi_r;
      ram_wdata = sum_hi[32] ? 32'hFFFF_FFFF : sum_hi[31:0];
    end
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[3:0];
      ram_wdata = 32'd0;
    end
  end

  // Status to the controller.
  always_comb begin
    status.op        = op_r;
    status.sample_ok = (freq_r >= FREQ_MIN_Q4) && (freq_r <= FREQ_MAX_Q4) &&
                       (wgt_r != 9'd0);
    status.log_last  = (cnt == 5'd15);
    status.mac_done  = s3_v && (s3_k == 5'(NKEYS - 1));
    status.div_last  = (cnt == 5'd15);
    status.clr_last  = (cnt == 5'(NBINS - 1));
  end

  // Request capture, mapping and histogram sequencing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      freq_r <= in_data[15:0];
      wgt_r  <= in_data[24:16];
      dt_r   <= in_data[40:25];
    end
    if (cmd.log_init || cmd.div_init || cmd.clr_init) begin
      cnt <= 5'd0;
    end else if (cmd.log_step || cmd.div_step || cmd.clr_step) begin
      cnt <= cnt + 5'd1;
    end
    if (cmd.log_init) begin
      e_r    <= e_comb;
      m_r    <= 16'(32'(freq_r) << (4'd15 - e_comb));
      frac_r <= 16'd0;
    end
    if (cmd.log_step) begin
      if (sq15[16]) begin
        m_r    <= sq15[16:1];
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        m_r    <= sq15[15:0];
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
    if (cmd.pos1) begin
      x_r <= 16'((22'({e_r, frac_r}) * 22'd3 + 22'd32) >> 6);
    end
    if (cmd.pos2) begin
      p_r <= (p0 >= POS_SPAN) ? 12'(p0 - POS_SPAN) : 12'(p0);
    end
    if (cmd.pos3) begin
      lo_r   <= p_r[11:8];
      hi_r   <= (p_r[11:8] == 4'(NBINS - 1)) ? 4'd0 : p_r[11:8] + 4'd1;
      part_r <= 9'(wprod >> 8);
      rest_r <= wclip - 9'(wprod >> 8);
    end
  end

  // Scoring pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
    end else begin
      if (cmd.mac_start) begin
        iss_act <= 1'b1;
      end else if (iss_act && iss_i == 4'(NBINS - 1) && iss_k == 5'(NKEYS - 1)) begin
        iss_act <= 1'b0;
      end
      s1_v <= iss_act;
      s2_v <= s1_v;
      s3_v <= s2_v && s2_last;
    end
  end

  // Scoring pipeline data: issue, multiply, accumulate, pick best.
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      iss_k <= 5'd0;
      iss_i <= 4'd0;
    end else if (iss_act) begin
      if (iss_i == 4'(NBINS - 1)) begin
        iss_i <= 4'd0;
        iss_k <= iss_k + 5'd1;
      end else begin
        iss_i <= iss_i + 4'd1;
      end
    end
    s1_k    <= iss_k;
    s1_i    <= iss_i;
    s2_k    <= s1_k;
    s2_last <= (s1_i == 4'(NBINS - 1));
    p2      <= 43'(ram_rdata) * 43'(prof_val(s1_k >= 5'd12, pidx));
    if (cmd.mac_start) begin
      acc   <= 48'd0;
      total <= 53'd0;
    end else begin
      if (s2_v) begin
        if (s2_last) begin
          fin_r <= acc + 48'(p2);
          s3_k  <= s2_k;
          acc   <= 48'd0;
        end else begin
          acc <= acc + 48'(p2);
        end
      end
      if (s3_v) begin
        total <= total + 53'(fin_r);
        if (s3_k == 5'd0 || fin_r > best) begin
          best   <= fin_r;
          best_k <= s3_k;
        end
      end
    end
  end

  // Restoring divider for best over total.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      if (53'(best) >= total) begin
        rem <= 53'(best) - total;
        quo <= 17'd1;
      end else begin
        rem <= 53'(best);
        quo <= 17'd0;
      end
    end else if (cmd.div_step) begin
      if (rem2 >= 54'(total)) begin
        rem <= 53'(rem2 - 54'(total));
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= 53'(rem2);
        quo <= {quo[15:0], 1'b0};
      end
    end
  end

  // Voting state, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      voting     <= VOTING_RST;
      cand_root  <= 4'd0;
      cand_minor <= 1'b0;
      cand_conf  <= 17'd0;
      conf_root  <= 4'd0;
      conf_minor <= 1'b0;
      conf_level <= 17'd0;
      hold_ms    <= 32'd0;
    end else begin
      if (cfg_we) begin
        voting <= cfg_wdata;
      end
      if (cmd.clr_init) begin
        hold_ms <= 32'd0;
      end
      if (cmd.key_upd) begin
        if (new_root == cand_root && new_minor == cand_minor) begin
          hold_ms <= hold_new;
          if (hold_new >= 32'(voting)) begin
            conf_root  <= cand_root;
            conf_minor <= cand_minor;
            conf_level <= cand_conf;
          end
        end else begin
          cand_root  <= new_root;
          cand_minor <= new_minor;
          cand_conf  <= new_conf;
          hold_ms    <= 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'd0, cand_minor, cand_root, conf_level, conf_minor, conf_root};
    end
  end

endmodule

`default_nettype wire

// File: design/mkd_ctrl.sv
// ----------------------------------------------------------------------------
// Musical key detector controller
// Sequences one request at a time through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "musical_key_detector_core_defines.svh"

module mkd_ctrl
  import mkd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_INIT_CLR, S_INIT_SWEEP, S_IDLE, S_DECODE, S_LOG_INIT, S_LOG,
    S_POS1, S_POS2, S_POS3, S_RD_LO, S_WR_LO, S_RD_HI, S_WR_HI,
    S_MAC_INIT, S_MAC, S_DIV_INIT, S_DIV, S_KEY, S_CLR_INIT, S_CLR, S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Commands decoded from the state.
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.log_init  = (state == S_LOG_INIT);
    cmd.log_step  = (state == S_LOG);
    cmd.pos1      = (state == S_POS1);
    cmd.pos2      = (state == S_POS2);
    cmd.pos3      = (state == S_POS3);
    cmd.rd_lo     = (state == S_RD_LO);
    cmd.wr_lo     = (state == S_WR_LO);
    cmd.rd_hi     = (state == S_RD_HI);
    cmd.wr_hi     = (state == S_WR_HI);
    cmd.mac_start = (state == S_MAC_INIT);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV);
    cmd.key_upd   = (state == S_KEY);
    cmd.clr_init  = (state == S_CLR_INIT) || (state == S_INIT_CLR);
    cmd.clr_step  = (state == S_CLR) || (state == S_INIT_SWEEP);
    cmd.out_load  = (state == S_OUT) && out_free;
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT_CLR;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT_CLR:   state <= S_INIT_SWEEP;
        S_INIT_SWEEP: if (status.clr_last) state <= S_IDLE;
        S_IDLE:       if (s_tvalid) state <= S_DECODE;
        S_DECODE: begin
          case (status.op)
            OP_SAMPLE: state <= status.sample_ok ? S_LOG_INIT : S_OUT;
            OP_TICK:   state <= S_MAC_INIT;
            OP_CLEAR:  state <= S_CLR_INIT;
            default:   state <= S_OUT;
          endcase
        end
        S_LOG_INIT:   state <= S_LOG;
        S_LOG:        if (status.log_last) state <= S_POS1;
        S_POS1:       state <= S_POS2;
        S_POS2:       state <= S_POS3;
        S_POS3:       state <= S_RD_LO;
        S_RD_LO:      state <= S_WR_LO;
        S_WR_LO:      state <= S_RD_HI;
        S_RD_HI:      state <= S_WR_HI;
        S_WR_HI:      state <= S_OUT;
        S_MAC_INIT:   state <= S_MAC;
        S_MAC:        if (status.mac_done) state <= S_DIV_INIT;
        S_DIV_INIT:   state <= S_DIV;
        S_DIV:        if (status.div_last) state <= S_KEY;
        S_KEY:        state <= S_OUT;
        S_CLR_INIT:   state <= S_CLR;
        S_CLR:        if (status.clr_last) state <= S_OUT;
        S_OUT:        if (out_free) state <= S_IDLE;
        default:      state <= S_IDLE;
      endcase
    end
  end

  // A pending result is never overwritten.
  `MKD_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !m_tvalid || m_tready)
  // Scoring completion moves straight on to the divider.
  `MKD_ASSERT_NXT(a_mac_to_div, clk, rst, state == S_MAC && status.mac_done, state == S_DIV_INIT)
  // An accepted request is decoded in the next cycle and blocks further input.
  `MKD_ASSERT_NXT(a_accept_decode, clk, rst, s_tvalid && s_tready, state == S_DECODE && !s_tready)

endmodule

`default_nettype wire

// File: design/musical_key_detector_core.sv
// ----------------------------------------------------------------------------
// Musical key detector core
// Pitch-class histogram with profile-correlation key finding and voting.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the opcode (sample,
//   tick, clear, no-op), s_tdata carries frequency, weight and tick time.
//   Every request produces exactly one result on the m_ channel holding the
//   confirmed key, its confidence and the current candidate key.
//   One request is processed at a time. A sample's time is set by the 16
//   squaring steps of the log2 unit. A tick's time is set by the single
//   multiply-accumulate unit scoring 24 keys over 12 bins plus a 17-step
//   divider. A clear zeroes the histogram one bin at a time. The result
//   sits in an output register, so the next request is accepted while it
//   waits; the block stalls in its final step only when a second result is
//   ready and the receiver still holds m_tready low. After rst the histogram
//   is swept to zero before s_tready rises; cfg_we writes the voting time at
//   any clock edge outside reset.
// ----------------------------------------------------------------------------
`default_nettype none

module musical_key_detector_core
  import mkd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // frequency_q4[15:0], sample_weight[24:16], tick_ms[40:25]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // key_root[3:0], key_minor[4], key_confidence[21:5],
                                      // candidate_root[25:22], candidate_minor[26]
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  cmd_t        cmd;
  status_t     status;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  // Sequencer.
  mkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and key state.
  mkd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_op     (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (m_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Pitch-class histogram.
  mkd_ram #(
    .WIDTH (32),
    .DEPTH (NBINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
